@@ src/text_integer_field_scanner_macros.svh @@
// Assertion helpers shared by the scanner modules.
// Each macro expects aclk and aresetn to be visible where it is used.
`ifndef TEXT_INTEGER_FIELD_SCANNER_MACROS_SVH
`define TEXT_INTEGER_FIELD_SCANNER_MACROS_SVH

// Same-cycle implication.
`define TIFS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tifs: same-cycle check failed");

// Next-cycle implication.
`define TIFS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tifs: next-cycle check failed");

`endif

@@ src/tifs_pkg.sv @@
`default_nettype none
package tifs_pkg;

    // Radix selection codes; the unused code behaves as decimal.
    localparam logic [1:0] RADIX_DEC = 2'd0;
    localparam logic [1:0] RADIX_HEX = 2'd1;
    localparam logic [1:0] RADIX_OCT = 2'd2;

    // Register indexes (word address bit 2).
    localparam logic REG_RADIX = 1'b0;
    localparam logic REG_WIDE  = 1'b1;

    // Result queue depth; must be a power of two and at least two.
    localparam int RES_DEPTH = 4;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_UP_X   = 8'h58;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_LO_X   = 8'h78;

    typedef enum logic [1:0] {
        STAT_FIELD    = 2'd0,
        STAT_MISMATCH = 2'd1,
        STAT_END      = 2'd2
    } status_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] value;
        logic [7:0]  field_count;
        logic        last_of_run;
    } res_t;

    // Up to two results from one text byte, first in r0.
    typedef struct packed {
        logic v0;
        logic v1;
        res_t r0;
        res_t r1;
    } step_out_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } digit_t;

    function automatic digit_t digit_of(input logic [7:0] c, input logic is_hex,
                                        input logic is_oct);
        digit_t     res;
        logic [7:0] off;
        res.ok  = 1'b0;
        res.val = 4'd0;
        off     = 8'd0;
        if (is_oct) begin
            if (c >= CH_ZERO && c <= CH_SEVEN) begin
                off = c - CH_ZERO;
                res.ok = 1'b1;
            end
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            off = c - CH_ZERO;
            res.ok = 1'b1;
        end else if (is_hex && c >= CH_UP_A && c <= CH_UP_F) begin
            off = c - CH_UP_A + 8'd10;
            res.ok = 1'b1;
        end else if (is_hex && c >= CH_LO_A && c <= CH_LO_F) begin
            off = c - CH_LO_A + 8'd10;
            res.ok = 1'b1;
        end
        res.val = off[3:0];
        return res;
    endfunction

    function automatic res_t make_res(input status_t st, input logic [31:0] v,
                                      input logic [7:0] cnt);
        res_t r;
        r.status      = st;
        r.value       = v;
        r.field_count = cnt;
        r.last_of_run = 1'b0;
        return r;
    endfunction

endpackage
`default_nettype wire

@@ src/tifs_step.sv @@
`default_nettype none
`include "text_integer_field_scanner_macros.svh"
module tifs_step (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                item_en,
    input  logic [7:0]          ch,
    input  logic                eos_flag,
    input  logic [1:0]          radix_mode,
    input  logic                wide_mode,
    output tifs_pkg::step_out_t res_out
);
    import tifs_pkg::*;

    typedef enum logic [4:0] {
        PH_SKIP    = 5'b00001,
        PH_NEED    = 5'b00010,
        PH_HEXZERO = 5'b00100,
        PH_DIGITS  = 5'b01000,
        PH_STOPPED = 5'b10000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        neg_reg, neg_next;
    logic [31:0] acc_reg, acc_next;
    logic [7:0]  fields_done_reg, fields_done_next;

    logic        is_hex, is_oct, is_dec, eos, is_ws;
    digit_t      dig;
    logic [31:0] acc_step, fin_signed, fin_val;
    logic [7:0]  cnt_inc;

    // Outcome of this byte opening a new field.
    phase_t      st_phase;
    logic        st_neg, st_mis;
    logic [31:0] st_acc;

    step_out_t   out_c;

    assign is_hex = (radix_mode == RADIX_HEX);
    assign is_oct = (radix_mode == RADIX_OCT);
    assign is_dec = !is_hex && !is_oct;
    assign eos    = eos_flag || (ch == CH_NUL);
    assign is_ws  = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_CR) || (ch == CH_LF);
    assign dig    = digit_of(ch, is_hex, is_oct);

    always_comb begin
        if (is_hex) begin
            acc_step = {acc_reg[27:0], dig.val};
        end else if (is_oct) begin
            acc_step = {acc_reg[28:0], dig.val[2:0]};
        end else begin
            acc_step = {acc_reg[28:0], 3'd0} + {acc_reg[30:0], 1'b0} + {28'd0, dig.val};
        end
    end

    assign fin_signed = neg_reg ? (32'd0 - acc_reg) : acc_reg;
    assign fin_val    = wide_mode ? fin_signed : {16'd0, fin_signed[15:0]};
    assign cnt_inc    = (fields_done_reg == 8'hFF) ? fields_done_reg : fields_done_reg + 8'd1;

    always_comb begin
        st_phase = PH_SKIP;
        st_neg   = 1'b0;
        st_acc   = 32'd0;
        st_mis   = 1'b0;
        priority if (is_ws) begin
            st_phase = PH_SKIP;
        end else if (is_dec && (ch == CH_MINUS || ch == CH_PLUS)) begin
            st_phase = PH_NEED;
            st_neg   = (ch == CH_MINUS);
        end else if (is_hex && ch == CH_DOLLAR) begin
            st_phase = PH_NEED;
        end else if (is_hex && ch == CH_ZERO) begin
            st_phase = PH_HEXZERO;
        end else if (dig.ok) begin
            st_phase = PH_DIGITS;
            st_acc   = {28'd0, dig.val};
        end else begin
            st_phase = PH_STOPPED;
            st_mis   = 1'b1;
        end
    end

    always_comb begin
        phase_next       = phase_reg;
        neg_next         = neg_reg;
        acc_next         = acc_reg;
        fields_done_next = fields_done_reg;
        out_c.v0 = 1'b0;
        out_c.v1 = 1'b0;
        out_c.r0 = make_res(STAT_END, 32'd0, fields_done_reg);
        out_c.r1 = make_res(STAT_END, 32'd0, cnt_inc);
        if (eos) begin
            out_c.v0 = 1'b1;
            if (phase_reg == PH_DIGITS || phase_reg == PH_HEXZERO) begin
                out_c.r0 = make_res(STAT_FIELD, fin_val, cnt_inc);
                out_c.v1 = 1'b1;
            end
            phase_next       = PH_SKIP;
            neg_next         = 1'b0;
            acc_next         = 32'd0;
            fields_done_next = 8'd0;
        end else begin
            unique case (phase_reg)
                PH_STOPPED: begin
                    phase_next = PH_STOPPED;
                end
                PH_NEED: begin
                    if (dig.ok) begin
                        acc_next   = {28'd0, dig.val};
                        phase_next = PH_DIGITS;
                    end else begin
                        out_c.v0   = 1'b1;
                        out_c.r0   = make_res(STAT_MISMATCH, 32'd0, fields_done_reg);
                        phase_next = PH_STOPPED;
                    end
                end
                PH_HEXZERO, PH_DIGITS: begin
                    if (phase_reg == PH_HEXZERO && is_hex
                        && (ch == CH_UP_X || ch == CH_LO_X)) begin
                        phase_next = PH_NEED;
                    end else if (dig.ok) begin
                        acc_next   = acc_step;
                        phase_next = PH_DIGITS;
                    end else begin
                        // Field closes; this byte opens the next one.
                        out_c.v0         = 1'b1;
                        out_c.r0         = make_res(STAT_FIELD, fin_val, cnt_inc);
                        out_c.v1         = st_mis;
                        out_c.r1         = make_res(STAT_MISMATCH, 32'd0, cnt_inc);
                        fields_done_next = cnt_inc;
                        phase_next       = st_phase;
                        neg_next         = st_neg;
                        acc_next         = st_acc;
                    end
                end
                default: begin
                    out_c.v0   = st_mis;
                    out_c.r0   = make_res(STAT_MISMATCH, 32'd0, fields_done_reg);
                    phase_next = st_phase;
                    neg_next   = st_neg;
                    acc_next   = st_acc;
                end
            endcase
        end
        out_c.r0.last_of_run = !out_c.v1;
        out_c.r1.last_of_run = 1'b1;
    end

    assign res_out = out_c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_SKIP;
            neg_reg         <= 1'b0;
            acc_reg         <= 32'd0;
            fields_done_reg <= 8'd0;
        end else if (item_en) begin
            phase_reg       <= phase_next;
            neg_reg         <= neg_next;
            acc_reg         <= acc_next;
            fields_done_reg <= fields_done_next;
        end
    end

    `TIFS_ASSERT_IMP(a_second_needs_first, item_en && out_c.v1, out_c.v0)
    `TIFS_ASSERT_NXT(a_stop_holds, item_en && phase_reg == PH_STOPPED && !eos, phase_reg == PH_STOPPED)
    `TIFS_ASSERT_NXT(a_end_clears, item_en && eos, phase_reg == PH_SKIP && fields_done_reg == 8'd0)

endmodule
`default_nettype wire

@@ src/tifs_res_fifo.sv @@
`default_nettype none
`include "text_integer_field_scanner_macros.svh"
module tifs_res_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_en,
    input  tifs_pkg::step_out_t push_in,
    output logic                room,
    output logic                out_valid,
    input  logic                out_ready,
    output tifs_pkg::res_t      out_res
);
    import tifs_pkg::*;

    localparam int PtrW = $clog2(RES_DEPTH);
    localparam int CntW = $clog2(RES_DEPTH + 1);

    res_t            mem_reg [RES_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next, wr_ptr_p1;
    logic [CntW-1:0] count_reg, count_next;
    logic            push0, push1, pop;

    assign push0     = push_en && push_in.v0;
    assign push1     = push_en && push_in.v1;
    assign pop       = out_valid && out_ready;
    assign wr_ptr_p1 = wr_ptr_reg + PtrW'(1);

    assign wr_ptr_next = wr_ptr_reg + PtrW'(push0) + PtrW'(push1);
    assign rd_ptr_next = rd_ptr_reg + PtrW'(pop);
    assign count_next  = count_reg + CntW'(push0) + CntW'(push1) - CntW'(pop);

    // Room for a full pair, judged on the registered fill only.
    assign room      = (count_reg <= CntW'(RES_DEPTH - 2));
    assign out_valid = (count_reg != CntW'(0));
    assign out_res   = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push0) begin
            mem_reg[wr_ptr_reg] <= push_in.r0;
        end
        if (push1) begin
            mem_reg[wr_ptr_p1] <= push_in.r1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `TIFS_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CntW'(RES_DEPTH))
    `TIFS_ASSERT_NXT(a_pop_drains, pop && !push0, count_reg == $past(count_reg) - CntW'(1))

endmodule
`default_nettype wire

@@ src/text_integer_field_scanner.sv @@
`default_nettype none
// Text integer field scanner. Text bytes enter on the s_ stream, one byte per
// transfer, with s_tlast marking end of string (a zero byte counts as end of
// string too). Each byte is held in an input register and is converted in the
// cycle it leaves that register, and its results then pass through the
// result queue on their way to the m_ stream. The block takes one byte
// every cycle; a byte may give up to two results, which wait in a
// four-entry result queue, and the input stalls only while that queue has
// fewer than two free entries. radix_mode (address 0) and wide_mode
// (address 4) are written over the APB port and must only change while the
// block is idle.
module text_integer_field_scanner (
    input  logic        aclk,
    input  logic        aresetn,
    // Text input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,   // end_of_string
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] value, [39:32] field_count
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast,   // last_of_run
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tifs_pkg::*;

    logic [1:0]  radix_mode_reg;
    logic        wide_mode_reg;
    logic        cfg_wr;

    logic        in_valid_reg;
    logic [7:0]  in_ch_reg;
    logic        in_eos_reg;
    logic        fire, room;

    step_out_t   step_res;
    res_t        head;

    // Configuration registers. Only the word address bit selects a register.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_mode_reg <= RADIX_DEC;
            wide_mode_reg  <= 1'b0;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_RADIX) begin
                radix_mode_reg <= pwdata[1:0];
            end else begin
                wide_mode_reg <= pwdata[0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_WIDE) ? {31'd0, wide_mode_reg} : {30'd0, radix_mode_reg};

    // Input register. The held byte is converted as soon as the result queue
    // can take a pair, and a new byte may enter in the same cycle.
    assign fire     = in_valid_reg && room;
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_ch_reg  <= s_tdata;
            in_eos_reg <= s_tlast;
        end
    end

    tifs_step u_step (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_en    (fire),
        .ch         (in_ch_reg),
        .eos_flag   (in_eos_reg),
        .radix_mode (radix_mode_reg),
        .wide_mode  (wide_mode_reg),
        .res_out    (step_res)
    );

    tifs_res_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_en   (fire),
        .push_in   (step_res),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (head)
    );

    assign m_tdata = {head.field_count, head.value};
    assign m_tuser = head.status;
    assign m_tlast = head.last_of_run;

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking bench for the text integer field scanner.
//
// Text bytes go in on the s_ stream and the converted fields come back on the
// m_ stream. A model of the scanner inside the bench works out the results of
// every byte at the clock edge of its transfer and queues them. Each result
// transfer is then compared field by field with the oldest queued entry.
//
// Stimulus starts with a short table of hand-picked bytes and register writes.
// A random part follows, in phases, each with its own radix and width setting.
module tb_top;
    import tifs_pkg::*;

    // Code 3 is not a named radix; the scanner treats it as decimal.
    localparam logic [1:0] RADIX_SPARE = 2'd3;

    localparam int QUIET_LIMIT   = 2000; // cycles with no transfer before giving up
    localparam int HOLD_CYCLES   = 90;   // length of the long receiver hold-off
    localparam int SETTLE_CYCLES = 4;    // a byte with no result may still be in flight
    localparam int PHASES        = 9;
    localparam int PHASE_BYTES   = 6;
    localparam int SAT_FIELDS    = 258;  // enough fields to saturate the counter

    // Where the scanner stands between fields.
    typedef enum logic [2:0] {
        SCAN_SKIP,
        SCAN_NEED,
        SCAN_HEXZERO,
        SCAN_DIGITS,
        SCAN_STOPPED
    } scan_phase_t;

    // Rows of the directed table: one text byte or one register write.
    typedef enum logic [1:0] {
        ROW_BYTE,
        ROW_SET_RADIX,
        ROW_SET_WIDE
    } row_kind_t;

    typedef struct packed {
        row_kind_t  kind;
        logic [7:0] data;     // text byte, or the register value
        logic       last;     // end of string on s_tlast
        logic       has_ref;  // result written out by hand below
        status_t    ref_st;
        logic [7:0] ref_cnt;
    } row_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = 3'd0;
    logic [31:0] pwdata   = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // A hand-written result travels alongside the byte that causes it, so that
    // the monitor sees it at the same edge as the byte's transfer.
    logic        row_ref_valid = 1'b0;
    res_t        row_ref       = '0;

    // Copy of the registers, and the scanner state as the bench sees it.
    logic [1:0]  cfg_radix = RADIX_DEC;
    logic        cfg_wide  = 1'b0;
    scan_phase_t sc_phase  = SCAN_SKIP;
    logic        sc_neg    = 1'b0;
    logic [31:0] sc_acc    = 32'd0;
    logic [7:0]  sc_count  = 8'd0;

    res_t        due_results [$];
    int          fail_count    = 0;
    int          bytes_sent    = 0;
    bit          calm          = 1'b0; // no random idling on either side
    int          hold_requests = 0;
    int          holds_served  = 0;
    int          hold_left     = 0;

    text_integer_field_scanner u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Scanner model
    // ------------------------------------------------------------------

    // Value of c as a digit of the current radix, or -1 if it is not one.
    function automatic int digit_value(input logic [7:0] c);
        int v;
        v = -1;
        if (cfg_radix == RADIX_OCT) begin
            if (c >= CH_ZERO && c <= CH_SEVEN) v = c - CH_ZERO;
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            v = c - CH_ZERO;
        end else if (cfg_radix == RADIX_HEX) begin
            if (c >= CH_UP_A && c <= CH_UP_F) v = c - CH_UP_A + 10;
            else if (c >= CH_LO_A && c <= CH_LO_F) v = c - CH_LO_A + 10;
        end
        return v;
    endfunction

    task automatic post_result(input status_t st, input logic [31:0] v);
        res_t r;
        r.status      = st;
        r.value       = v;
        r.field_count = sc_count;
        r.last_of_run = 1'b0;
        due_results.push_back(r);
    endtask

    // The field ends: apply the sign, cut to width and count it.
    task automatic close_field();
        logic [31:0] v;
        v = sc_neg ? 32'd0 - sc_acc : sc_acc;
        if (!cfg_wide) v = v & 32'h0000_FFFF;
        if (sc_count != 8'd255) sc_count = sc_count + 8'd1;
        post_result(STAT_FIELD, v);
        sc_acc   = 32'd0;
        sc_neg   = 1'b0;
        sc_phase = SCAN_SKIP;
    endtask

    // A byte seen while looking for the start of a field.
    task automatic open_field(input logic [7:0] c);
        int d;
        d = digit_value(c);
        if (!(c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF)) begin
            sc_acc = 32'd0;
            sc_neg = 1'b0;
            if (cfg_radix != RADIX_HEX && cfg_radix != RADIX_OCT &&
                (c == CH_MINUS || c == CH_PLUS)) begin
                sc_neg   = (c == CH_MINUS);
                sc_phase = SCAN_NEED;
            end else if (cfg_radix == RADIX_HEX && c == CH_DOLLAR) begin
                sc_phase = SCAN_NEED;
            end else if (cfg_radix == RADIX_HEX && c == CH_ZERO) begin
                sc_phase = SCAN_HEXZERO;
            end else if (d >= 0) begin
                sc_acc   = 32'(d);
                sc_phase = SCAN_DIGITS;
            end else begin
                post_result(STAT_MISMATCH, 32'd0);
                sc_phase = SCAN_STOPPED;
            end
        end
    endtask

    // One accepted text byte; its results are appended to due_results.
    task automatic scan_byte(input logic [7:0] c, input logic eos_flag);
        int   n0;
        int   d;
        res_t r;
        n0 = due_results.size();
        d  = digit_value(c);
        if (eos_flag || c == CH_NUL) begin
            // A pending field is reported first; an unfinished sign or prefix
            // is simply dropped.
            if (sc_phase == SCAN_DIGITS || sc_phase == SCAN_HEXZERO) close_field();
            post_result(STAT_END, 32'd0);
            sc_phase = SCAN_SKIP;
            sc_neg   = 1'b0;
            sc_acc   = 32'd0;
            sc_count = 8'd0;
        end else if (sc_phase == SCAN_STOPPED) begin
            // Everything up to the end of the string is ignored.
        end else if (sc_phase == SCAN_NEED) begin
            if (d >= 0) begin
                sc_acc   = 32'(d);
                sc_phase = SCAN_DIGITS;
            end else begin
                post_result(STAT_MISMATCH, 32'd0);
                sc_phase = SCAN_STOPPED;
            end
        end else if (sc_phase == SCAN_HEXZERO && cfg_radix == RADIX_HEX &&
                     (c == CH_LO_X || c == CH_UP_X)) begin
            sc_phase = SCAN_NEED;
        end else if (sc_phase == SCAN_DIGITS || sc_phase == SCAN_HEXZERO) begin
            if (d >= 0) begin
                case (cfg_radix)
                    RADIX_HEX: sc_acc = (sc_acc << 4) | 32'(d);
                    RADIX_OCT: sc_acc = (sc_acc << 3) | 32'(d);
                    default:   sc_acc = sc_acc * 32'd10 + 32'(d);
                endcase
                sc_phase = SCAN_DIGITS;
            end else begin
                // The byte that ends a field goes on to start the next one.
                close_field();
                open_field(c);
            end
        end else begin
            sc_phase = SCAN_SKIP;
            open_field(c);
        end
        if (due_results.size() > n0) begin
            r = due_results.pop_back();
            r.last_of_run = 1'b1;
            due_results.push_back(r);
        end
    endtask

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("%s", msg);
    endfunction

    // ------------------------------------------------------------------
    // Monitor: both channels are sampled at the rising edge, before any
    // nonblocking update of that edge has landed.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        int   before_n;
        res_t exp_res;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                before_n = due_results.size();
                scan_byte(s_tdata, s_tlast);
                // Rows of the table with a result written out replace what
                // the model gives; the model state still moves on.
                if (row_ref_valid) begin
                    while (due_results.size() > before_n) void'(due_results.pop_back());
                    due_results.push_back(row_ref);
                end
            end
            if (m_tvalid && m_tready) begin
                if (due_results.size() == 0) begin
                    note_failure($sformatf(
                        "unexpected result: status %0d value %h count %0d last %b",
                        m_tuser, m_tdata[31:0], m_tdata[39:32], m_tlast));
                end else begin
                    exp_res = due_results.pop_front();
                    if (m_tuser !== exp_res.status || m_tdata[31:0] !== exp_res.value ||
                        m_tdata[39:32] !== exp_res.field_count ||
                        m_tlast !== exp_res.last_of_run) begin
                        note_failure($sformatf({"result mismatch: expected status %0d ",
                            "value %h count %0d last %b, got status %0d value %h ",
                            "count %0d last %b"},
                            exp_res.status, exp_res.value, exp_res.field_count,
                            exp_res.last_of_run, m_tuser, m_tdata[31:0],
                            m_tdata[39:32], m_tlast));
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, none while calm, and a long hold-off
    // whenever the sender asks for one. The hold-off is counted here.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (holds_served != hold_requests) begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_CYCLES;
            m_tready     <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= 34);
        end
    end

    // Watchdog: too long without any transfer means the block has hung.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one byte, with random gaps first, and return once its transfer
    // has happened. The caller is always just past a rising edge.
    task automatic send_byte(input logic [7:0] c, input logic eos_flag,
                             input logic with_ref, input res_t ref_res);
        while (!calm && $urandom_range(99) < 34) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid      <= 1'b1;
        s_tdata       <= c;
        s_tlast       <= eos_flag;
        row_ref_valid <= with_ref;
        row_ref       <= ref_res;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_text(input logic [7:0] c);
        send_byte(c, 1'b0, 1'b0, '0);
    endtask

    // Stop offering and wait until every expected result has come out.
    task automatic wait_drained(input int extra);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (due_results.size() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    // Register write: a setup phase, then an access phase. pready is honoured
    // although the block keeps it high.
    task automatic apb_write(input logic idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_RADIX) cfg_radix = val[1:0];
        else cfg_wide = val[0];
    endtask

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    // A random digit of the current radix, hex letters in either case.
    function automatic logic [7:0] pick_digit();
        int v;
        if (cfg_radix == RADIX_OCT) return CH_ZERO + 8'($urandom_range(7));
        if (cfg_radix != RADIX_HEX) return CH_ZERO + 8'($urandom_range(9));
        v = $urandom_range(15);
        if (v < 10) return CH_ZERO + 8'(v);
        return ($urandom_range(1) ? CH_UP_A : CH_LO_A) + 8'(v - 10);
    endfunction

    // One string of mostly well-formed fields. Now and then a sign or prefix
    // has no digits after it, or a stray byte is thrown in, which usually
    // stops the string. Left open, the string ends in the middle of things.
    task automatic send_fields(input int count, input bit closed);
        int i;
        int nblank;
        int roll;
        int ndig;
        for (i = 0; i < count; i++) begin
            nblank = ($urandom_range(99) < 40) ? 0 : $urandom_range(1, 2);
            repeat (nblank) send_text(pick_blank());
            roll = $urandom_range(99);
            if (cfg_radix == RADIX_HEX) begin
                if (roll < 20) begin
                    send_text(CH_DOLLAR);
                end else if (roll < 40) begin
                    send_text(CH_ZERO);
                    send_text($urandom_range(1) ? CH_LO_X : CH_UP_X);
                end
            end else if (cfg_radix != RADIX_OCT) begin
                if (roll < 20) send_text(CH_MINUS);
                else if (roll < 35) send_text(CH_PLUS);
            end
            // Mostly short fields; the long ones wrap past 16 and 32 bits.
            ndig = ($urandom_range(7) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
            if ($urandom_range(99) < 4) ndig = 0;
            repeat (ndig) send_text(pick_digit());
            if ($urandom_range(99) < 6) send_text(8'($urandom_range(1, 255)));
        end
        if (closed) begin
            // End of string mostly on tlast, where the byte itself is
            // ignored and so takes any value; otherwise a zero byte.
            if ($urandom_range(99) < 80) send_byte(8'($urandom_range(255)), 1'b1, 1'b0, '0);
            else send_text(CH_NUL);
        end
    endtask

    initial begin
        row_t       steps_table [28];
        res_t       typed;
        logic [1:0] radix;
        logic       wide;
        int         p;
        int         phase_start;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, starting from the reset setting (decimal, 16 bits).
        steps_table = '{
            // End of string straight after reset, every bit of the byte set.
            '{ROW_BYTE,      8'hFF,           1'b1, 1'b1, STAT_END,      8'd0},
            // A zero byte counts as end of string.
            '{ROW_BYTE,      CH_NUL,          1'b0, 1'b1, STAT_END,      8'd0},
            // Negative field, ended by white space.
            '{ROW_BYTE,      CH_TAB,          1'b0, 1'b0, STAT_FIELD,    8'd0},
            '{ROW_BYTE,      CH_MINUS,        1'b0, 1'b0, STAT_FIELD,    8'd0},
            '{ROW_BYTE,      CH_SEVEN,        1'b0, 1'b0, STAT_FIELD,    8'd0},
            '{ROW_BYTE,      CH_LF,           1'b0, 1'b0, STAT_FIELD,    8'd0},
            // Sign followed by a blank stops the string; the rest is ignored.
            '{ROW_BYTE,      CH_PLUS,         1'b0, 1'b0, STAT_FIELD,    8'd0},
            '{ROW_BYTE,      CH_SPACE,        1'b0, 1'b1, STAT_MISMATCH, 8'd1},
            '{ROW_BYTE,      8'h5A,           1'b0, 1'b0, STAT_FIELD,    8'd0},
            '{ROW_BYTE,      CH_NUL,          1'b1, 1'b1, STAT_END,      8'd1},
            // End just after a sign drops the unfinished field.
            '{ROW_BYTE,      CH_MINUS,        1'b0, 1'b0, STAT_FIELD,    8'd0},
            '{ROW_BYTE,      8'hA5,           1'b1, 1'b0, STAT_FIELD,    8'd0},
            '{ROW_SET_RADIX, 8'(RADIX_HEX),   1'b0, 1'b0, STAT_FIELD,    8'd0},
            '{ROW_SET_WIDE,  8'd1,            1'b0, 1'b0, STAT_FIELD,    8'd0},
            // Lone hex zero, then a byte that cannot start a field.
            '{ROW_BYTE,      CH_ZERO,         1'b0, 1'b0, STAT_FIELD,    8'd0},
            '{ROW_BYTE,      8'h47,           1'b0, 1'b0, STAT_FIELD,    8'd0},
            '{ROW_BYTE,      8'h80,           1'b1, 1'b0, STAT_FIELD,    8'd0},
            // Both hex prefixes; the second field ends with the string.
            '{ROW_BYTE,      CH_DOLLAR,       1'b0, 1'b0, STAT_FIELD,    8'd0},
            '{ROW_BYTE,      CH_LO_F,         1'b0, 1'b0, STAT_FIELD,    8'd0},
            '{ROW_BYTE,      CH_SPACE,        1'b0, 1'b0, STAT_FIELD,    8'd0},
            '{ROW_BYTE,      CH_ZERO,         1'b0, 1'b0, STAT_FIELD,    8'd0},
            '{ROW_BYTE,      CH_UP_X,         1'b0, 1'b0, STAT_FIELD,    8'd0},
            '{ROW_BYTE,      CH_UP_F,         1'b0, 1'b0, STAT_FIELD,    8'd0},
            '{ROW_BYTE,      8'h7F,           1'b1, 1'b0, STAT_FIELD,    8'd0},
            // The spare radix code scans as decimal.
            '{ROW_SET_RADIX, 8'(RADIX_SPARE), 1'b0, 1'b0, STAT_FIELD,    8'd0},
            '{ROW_BYTE,      CH_NINE,         1'b0, 1'b0, STAT_FIELD,    8'd0},
            '{ROW_BYTE,      CH_CR,           1'b0, 1'b0, STAT_FIELD,    8'd0},
            '{ROW_BYTE,      CH_NUL,          1'b0, 1'b0, STAT_FIELD,    8'd0}
        };

        foreach (steps_table[i]) begin
            case (steps_table[i].kind)
                ROW_SET_RADIX: begin
                    wait_drained(SETTLE_CYCLES);
                    apb_write(REG_RADIX, {24'd0, steps_table[i].data});
                end
                ROW_SET_WIDE: begin
                    wait_drained(SETTLE_CYCLES);
                    apb_write(REG_WIDE, {24'd0, steps_table[i].data});
                end
                default: begin
                    typed.status      = steps_table[i].ref_st;
                    typed.value       = 32'd0;
                    typed.field_count = steps_table[i].ref_cnt;
                    typed.last_of_run = 1'b1;
                    send_byte(steps_table[i].data, steps_table[i].last,
                              steps_table[i].has_ref, typed);
                end
            endcase
        end
        wait_drained(SETTLE_CYCLES);

        // Random part. Each phase picks a setting, writes both registers
        // while the block is idle, and sends strings. The first and third phases
        // run with no idling at all; the fifth starts with a string long enough
        // to saturate the field counter, and the receiver holds off while
        // the sender keeps offering it, so the result queue fills and the
        // input stalls. A phase may end in the middle of a field, so the
        // next setting takes over mid-field.
        for (p = 0; p < PHASES; p++) begin
            case (p)
                0:       begin radix = RADIX_DEC;   wide = 1'b0; end
                1:       begin radix = RADIX_HEX;   wide = 1'b1; end
                2:       begin radix = RADIX_OCT;   wide = 1'b0; end
                3:       begin radix = RADIX_SPARE; wide = 1'b1; end
                4:       begin radix = RADIX_HEX;   wide = 1'b0; end
                5:       begin radix = RADIX_OCT;   wide = 1'b1; end
                6:       begin radix = RADIX_DEC;   wide = 1'b1; end
                default: begin radix = 2'($urandom_range(3)); wide = 1'($urandom_range(1)); end
            endcase
            // Bits above the register are random; the block must ignore them.
            apb_write(REG_RADIX, ($urandom() & 32'hFFFF_FFFC) | {30'd0, radix});
            apb_write(REG_WIDE, ($urandom() & 32'hFFFF_FFFE) | {31'd0, wide});

            calm = (p == 0 || p == 2);
            if (p == 4) begin
                hold_requests <= hold_requests + 1;
                repeat (SAT_FIELDS) begin
                    send_text(pick_digit());
                    send_text(pick_blank());
                end
                send_byte(8'($urandom_range(255)), 1'b1, 1'b0, '0);
            end

            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
                send_fields($urandom_range(1, 3), 1'b1);
            if ($urandom_range(2) == 0) send_fields(1, 1'b0);
            calm = 1'b0;
            wait_drained(SETTLE_CYCLES);
        end

        // Finish off any string left open, then let the block run dry.
        send_byte(CH_NUL, 1'b1, 1'b0, '0);
        wait_drained(20);

        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ text_integer_field_scanner.f @@
+incdir+src
src/tifs_pkg.sv
src/tifs_step.sv
src/tifs_res_fifo.sv
src/text_integer_field_scanner.sv
test/tb_top.sv
